// ===== hw/rtl/swbd_pkg.sv =====
// swbd_pkg: shared types and constants of the sync word bit deframer
package swbd_pkg;

  // fixed field widths
  localparam int unsigned SWBD_PATTERN_W = 16;
  localparam int unsigned SWBD_TICKS_W   = 7;
  localparam int unsigned SWBD_BYTES_W   = 5;
  localparam int unsigned SWBD_PHASE_W   = 6;
  localparam int unsigned SWBD_BITIDX_W  = 3;
  localparam int unsigned SWBD_BYTEIDX_W = 4;
  localparam int unsigned SWBD_BYTE_W    = 8;
  localparam int unsigned SWBD_CFG_IDX_W = 2;

  // default history width
  localparam int unsigned SWBD_SYNC_BITS = 16;

  // register reset values
  localparam logic [SWBD_PATTERN_W-1:0] SWBD_PATTERN_RST = 16'hFF80;
  localparam logic [SWBD_TICKS_W-1:0]   SWBD_TICKS_RST   = 7'd9;
  localparam logic [SWBD_BYTES_W-1:0]   SWBD_BYTES_RST   = 5'd4;

  // clamp limits
  localparam logic [SWBD_TICKS_W-1:0] SWBD_TICKS_MAX = 7'd64;
  localparam logic [SWBD_BYTES_W-1:0] SWBD_BYTES_MAX = 5'd16;

  // configuration register indexes
  typedef enum logic [SWBD_CFG_IDX_W-1:0] {
    CFG_SYNC_PATTERN    = 2'd0,
    CFG_TICKS_PER_BIT   = 2'd1,
    CFG_BYTES_PER_FRAME = 2'd2
  } swbd_cfg_idx_t;

  // receiver mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_HUNT = 3'b010,
    MODE_DATA = 3'b100
  } swbd_mode_t;

endpackage

// ===== hw/rtl/sync_word_bit_deframer.sv =====
// sync_word_bit_deframer: sync word hunt and byte assembly over sampled pin levels
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_pin_level
//  out_    | output    | out_valid/out_stall| out_data_byte, out_frame_end
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock unless stalled: each tick updates the state in one pass and
// any byte lands in the result register on the same edge, visible the next cycle.
// in_stall rises only while the result register holds a byte that out_stall
// blocks; a new byte can replace it in the cycle it is taken.
// Synchronous active-low reset puts the block in idle with an empty result register
// and the registers at their defaults. cfg_ready is always high.
module sync_word_bit_deframer #(
  parameter int unsigned SYNC_BITS = swbd_pkg::SWBD_SYNC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tick input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_pin_level,
  // byte output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [swbd_pkg::SWBD_BYTE_W-1:0]      out_data_byte,
  output logic                                  out_frame_end,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swbd_pkg::SWBD_CFG_IDX_W-1:0]   cfg_index,
  input  logic [swbd_pkg::SWBD_PATTERN_W-1:0]   cfg_data
);
  import swbd_pkg::*;

  // compare width covers both the history and the pattern
  localparam int unsigned CMP_W = (SYNC_BITS > SWBD_PATTERN_W) ? SYNC_BITS : SWBD_PATTERN_W;

  // configuration registers
  logic [SWBD_PATTERN_W-1:0] sync_pattern_r;
  logic [SWBD_TICKS_W-1:0]   ticks_per_bit_r;
  logic [SWBD_BYTES_W-1:0]   bytes_per_frame_r;

  // receiver state
  swbd_mode_t                mode_r, mode_nxt;
  logic [SWBD_PHASE_W-1:0]   tick_phase_r, tick_phase_nxt;
  logic [SYNC_BITS-1:0]      history_r, history_nxt;
  logic [SWBD_BITIDX_W-1:0]  bit_index_r, bit_index_nxt;
  logic [SWBD_BYTEIDX_W-1:0] byte_index_r, byte_index_nxt;

  // result register
  logic                      out_valid_r;
  logic [SWBD_BYTE_W-1:0]    out_byte_r;
  logic                      out_end_r;

  logic                      accept;
  logic                      emit;
  logic [SWBD_BYTE_W-1:0]    emit_byte;
  logic                      emit_last;
  logic [SWBD_TICKS_W-1:0]   period_len;
  logic [SWBD_BYTES_W-1:0]   frame_len;
  logic [SYNC_BITS-1:0]      hist_sampled;
  logic                      period_end;
  logic                      last_byte;
  logic                      sync_hit;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r    <= SWBD_PATTERN_RST;
      ticks_per_bit_r   <= SWBD_TICKS_RST;
      bytes_per_frame_r <= SWBD_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_PATTERN:    sync_pattern_r    <= cfg_data;
        CFG_TICKS_PER_BIT:   ticks_per_bit_r   <= cfg_data[SWBD_TICKS_W-1:0];
        CFG_BYTES_PER_FRAME: bytes_per_frame_r <= cfg_data[SWBD_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped period and frame lengths
  always_comb begin
    if (ticks_per_bit_r == '0) begin
      period_len = SWBD_TICKS_W'(1);
    end else if (ticks_per_bit_r > SWBD_TICKS_MAX) begin
      period_len = SWBD_TICKS_MAX;
    end else begin
      period_len = ticks_per_bit_r;
    end
    if (bytes_per_frame_r == '0) begin
      frame_len = SWBD_BYTES_W'(1);
    end else if (bytes_per_frame_r > SWBD_BYTES_MAX) begin
      frame_len = SWBD_BYTES_MAX;
    end else begin
      frame_len = bytes_per_frame_r;
    end
  end

  // sample on the first tick of a bit period
  always_comb begin
    hist_sampled = history_r;
    if (tick_phase_r == '0) begin
      if (mode_r == MODE_HUNT) begin
        hist_sampled = {history_r[SYNC_BITS-2:0], in_pin_level};
      end else begin
        hist_sampled = SYNC_BITS'({history_r[SWBD_BYTE_W-2:0], in_pin_level});
      end
    end
  end

  assign period_end = ({1'b0, tick_phase_r} + SWBD_TICKS_W'(1)) >= period_len;
  assign last_byte  = ({1'b0, byte_index_r} + SWBD_BYTES_W'(1)) >= frame_len;
  assign sync_hit   = CMP_W'(hist_sampled) == CMP_W'(sync_pattern_r);

  // per-tick state update
  always_comb begin
    mode_nxt       = mode_r;
    tick_phase_nxt = tick_phase_r;
    history_nxt    = history_r;
    bit_index_nxt  = bit_index_r;
    byte_index_nxt = byte_index_r;
    emit           = 1'b0;
    emit_byte      = hist_sampled[SWBD_BYTE_W-1:0];
    emit_last      = last_byte;
    unique case (mode_r)
      MODE_HUNT, MODE_DATA: begin
        history_nxt = hist_sampled;
        if (!period_end) begin
          tick_phase_nxt = tick_phase_r + SWBD_PHASE_W'(1);
        end else begin
          tick_phase_nxt = '0;
          if (mode_r == MODE_HUNT) begin
            if (sync_hit) begin
              mode_nxt       = MODE_DATA;
              history_nxt    = '0;
              bit_index_nxt  = '0;
              byte_index_nxt = '0;
            end
          end else if (bit_index_r == SWBD_BITIDX_W'(7)) begin
            emit          = 1'b1;
            bit_index_nxt = '0;
            history_nxt   = '0;
            if (last_byte) begin
              mode_nxt       = MODE_IDLE;
              byte_index_nxt = '0;
            end else begin
              byte_index_nxt = byte_index_r + SWBD_BYTEIDX_W'(1);
            end
          end else begin
            bit_index_nxt = bit_index_r + SWBD_BITIDX_W'(1);
          end
        end
      end
      default: begin
        // idle: a high level starts the hunt, this tick is no sample
        if (in_pin_level) begin
          mode_nxt       = MODE_HUNT;
          tick_phase_nxt = '0;
          history_nxt    = '0;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      tick_phase_r <= '0;
      history_r    <= '0;
      bit_index_r  <= '0;
      byte_index_r <= '0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      tick_phase_r <= tick_phase_nxt;
      history_r    <= history_nxt;
      bit_index_r  <= bit_index_nxt;
      byte_index_r <= byte_index_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte_r <= emit_byte;
      out_end_r  <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_byte_r;
  assign out_frame_end = out_end_r;

endmodule

// ===== hw/rtl/swbd_checker.sv =====
// swbd_checker: port-level checks of the sync word bit deframer, with its bind
module swbd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [swbd_pkg::SWBD_BYTE_W-1:0]   out_data_byte,
  input logic                               out_frame_end
);
  import swbd_pkg::*;

  // a blocked byte holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) && $stable(out_frame_end))
    else $error("stalled output item changed");

  // input backpressure only from a blocked result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output item");

  // every new byte comes from an accepted tick
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("output item without an accepted input item");

  // a taken byte is not shown again without a new tick
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
    else $error("output item repeated");

endmodule

bind sync_word_bit_deframer swbd_checker u_swbd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_data_byte (out_data_byte),
  .out_frame_end (out_frame_end)
);

// ===== sim/tb_sync_word_bit_deframer.sv =====
// testbench for sync_word_bit_deframer: framed and noisy pin streams checked against a predictor
module tb_sync_word_bit_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import swbd_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int MIN_ITEMS   = 550;
  localparam int MIN_BYTES   = 24;
  localparam int END_WAIT    = 20000;
  localparam logic [SWBD_CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PATTERN} sink_mode_t;
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  typedef struct packed {
    logic [SWBD_BYTE_W-1:0] data_byte;
    logic                   frame_end;
  } byte_rec_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_pin_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [SWBD_BYTE_W-1:0] out_data_byte;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SWBD_CFG_IDX_W-1:0] cfg_index = '0;
  logic [SWBD_PATTERN_W-1:0] cfg_data = '0;

  // pending pin samples and bytes still owed by the block
  logic      pin_q[$];
  byte_rec_t byte_q[$];

  int errors = 0;
  int items_sent = 0;
  int bytes_seen = 0;

  // sender and receiver knobs
  bit         tx_bursty = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  sink_mode_t sink_mode = SINK_FREE;
  int         sink_cyc = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;
  bit         hold_ack = 1'b0;

  // predictor copy of registers and deframer state
  logic [SWBD_PATTERN_W-1:0] sync_word;
  logic [SWBD_TICKS_W-1:0]   ticks_reg;
  logic [SWBD_BYTES_W-1:0]   bytes_reg;
  swbd_mode_t                link_mode;
  logic [SWBD_PHASE_W-1:0]   tick_pos;
  logic [SWBD_SYNC_BITS-1:0] history;
  logic [SWBD_BITIDX_W-1:0]  bit_pos;
  logic [SWBD_BYTEIDX_W-1:0] byte_pos;

  sync_word_bit_deframer DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_err(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // effective bit period and frame length after clamping
  function automatic int period_ticks();
    if (ticks_reg == 0) return 1;
    if (ticks_reg > SWBD_TICKS_MAX) return SWBD_TICKS_MAX;
    return ticks_reg;
  endfunction

  function automatic int frame_bytes();
    if (bytes_reg == 0) return 1;
    if (bytes_reg > SWBD_BYTES_MAX) return SWBD_BYTES_MAX;
    return bytes_reg;
  endfunction

  // one timer tick through the deframer
  task automatic deframe_tick(input logic pin);
    logic      is_last;
    byte_rec_t rec;
    if (link_mode != MODE_HUNT && link_mode != MODE_DATA) begin
      // idle: a high level starts the hunt, the tick itself is not a sample
      if (pin) begin
        link_mode = MODE_HUNT;
        tick_pos = '0;
        history = '0;
      end
    end else begin
      if (tick_pos == 0) begin
        if (link_mode == MODE_HUNT) history = {history[SWBD_SYNC_BITS-2:0], pin};
        else history = SWBD_SYNC_BITS'({history[6:0], pin});
      end
      if (int'(tick_pos) + 1 < period_ticks()) begin
        tick_pos = tick_pos + SWBD_PHASE_W'(1);
      end else begin
        tick_pos = '0;
        if (link_mode == MODE_HUNT) begin
          if (history == sync_word) begin
            link_mode = MODE_DATA;
            history = '0;
            bit_pos = '0;
            byte_pos = '0;
          end
        end else if (bit_pos == 3'd7) begin
          is_last = (int'(byte_pos) + 1) >= frame_bytes();
          rec.data_byte = history[7:0];
          rec.frame_end = is_last;
          byte_q.push_back(rec);
          bit_pos = '0;
          history = '0;
          if (is_last) begin
            link_mode = MODE_IDLE;
            byte_pos = '0;
          end else begin
            byte_pos = byte_pos + SWBD_BYTEIDX_W'(1);
          end
        end else begin
          bit_pos = bit_pos + SWBD_BITIDX_W'(1);
        end
      end
    end
  endtask

  // predictor: accepted ticks see the registers from before this edge's write
  always @(posedge clk) begin
    if (!rst_n) begin
      sync_word = SWBD_PATTERN_RST;
      ticks_reg = SWBD_TICKS_RST;
      bytes_reg = SWBD_BYTES_RST;
      link_mode = MODE_IDLE;
      tick_pos = '0;
      history = '0;
      bit_pos = '0;
      byte_pos = '0;
    end else begin
      if (in_valid && !in_stall) deframe_tick(in_pin_level);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC_PATTERN:    sync_word = cfg_data;
          CFG_TICKS_PER_BIT:   ticks_reg = cfg_data[SWBD_TICKS_W-1:0];
          CFG_BYTES_PER_FRAME: bytes_reg = cfg_data[SWBD_BYTES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // sender: bursts with gaps, item held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pin_q.size() > 0) begin
        in_valid <= 1'b1;
        in_pin_level <= pin_q.pop_front();
        if (tx_bursty) begin
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold-off on request, otherwise its own stall pattern
  always @(posedge clk) begin
    sink_cyc <= sink_cyc + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (sink_mode)
        SINK_FREE:  out_stall <= 1'b0;
        SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        SINK_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:    out_stall <= (sink_cyc % 7) < 3;
      endcase
    end
  end

  // monitor: each byte taken against the oldest expectation
  always @(posedge clk) begin
    byte_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (byte_q.size() == 0) begin
        report_err($sformatf("unexpected byte %02h frame_end %0b", out_data_byte,
                             out_frame_end));
      end else begin
        want = byte_q.pop_front();
        if (out_data_byte !== want.data_byte)
          report_err($sformatf("data_byte %02h, want %02h", out_data_byte, want.data_byte));
        if (out_frame_end !== want.frame_end)
          report_err($sformatf("frame_end %0b, want %0b", out_frame_end, want.frame_end));
      end
    end
  end

  // register write, called right after a rising edge
  task automatic write_reg(input logic [SWBD_CFG_IDX_W-1:0] idx,
                           input logic [SWBD_PATTERN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // nothing pending, nothing owed, then a few cycles for the last tick to settle
  task automatic wait_quiet();
    while (pin_q.size() != 0 || in_valid || byte_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one bit period: sample on the first tick, the rest don't care
  task automatic push_period(ref logic seq[$], input logic b);
    int n;
    n = period_ticks();
    seq.push_back(b);
    repeat (n - 1) seq.push_back(1'($urandom_range(0, 1)));
  endtask

  // one frame, picking up from wherever the deframer is when from_idle is clear
  task automatic queue_frame(input fill_t fill, input bit broken, input bit from_idle);
    logic seq[$];
    logic [7:0] val;
    int sync_len, data_bits, nb, skip, cut;
    sync_len = SWBD_SYNC_BITS;
    data_bits = frame_bytes() * 8;
    if (!from_idle && (link_mode == MODE_HUNT || link_mode == MODE_DATA)) begin
      // finish the current bit period first
      if (tick_pos != 0) begin
        skip = period_ticks() - int'(tick_pos);
        if (skip < 1) skip = 1;
        repeat (skip) seq.push_back(1'($urandom_range(0, 1)));
      end
      if (link_mode == MODE_DATA) begin
        nb = frame_bytes() - int'(byte_pos);
        if (nb < 1) nb = 1;
        data_bits = nb * 8 - int'(bit_pos);
        sync_len = 0;
      end
    end else begin
      repeat ($urandom_range(0, 3)) seq.push_back(1'b0);
      seq.push_back(1'b1);
      // shortest prefix of the sync word that matches from a cleared history
      for (sync_len = 1; sync_len < SWBD_SYNC_BITS; sync_len++)
        if ((sync_word >> (SWBD_SYNC_BITS - sync_len)) == sync_word) break;
    end
    for (int k = 0; k < sync_len; k++)
      push_period(seq, sync_word[SWBD_SYNC_BITS - 1 - k]);
    val = '0;
    for (int k = 0; k < data_bits; k++) begin
      if (k % 8 == 0) begin
        case (fill)
          FILL_ONES:  val = 8'hFF;
          FILL_ZEROS: val = 8'h00;
          default:    val = 8'($urandom_range(0, 255));
        endcase
      end
      push_period(seq, val[7 - (k % 8)]);
    end
    // broken frame: cut off at a random point
    if (broken && seq.size() > 1) begin
      cut = $urandom_range(0, seq.size() - 2);
      seq = seq[0:cut];
    end
    items_sent += seq.size();
    foreach (seq[k]) pin_q.push_back(seq[k]);
  endtask

  // main sequence
  initial begin
    int tk, nb, kind, waited;
    logic [SWBD_PATTERN_W-1:0] word;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero period and zero frame length clamp to one, zero sync word
    write_reg(CFG_TICKS_PER_BIT, '0);
    write_reg(CFG_BYTES_PER_FRAME, '0);
    write_reg(CFG_SYNC_PATTERN, '0);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    queue_frame(FILL_ONES, 1'b0, 1'b0);
    queue_frame(FILL_ZEROS, 1'b0, 1'b1);
    wait_quiet();

    // phases: extremes first, then random settings
    for (int ph = 0; ph < 3 || items_sent < MIN_ITEMS || bytes_seen < MIN_BYTES; ph++) begin
      wait_quiet();
      kind = $urandom_range(0, 7);
      word = (kind == 0) ? 16'($urandom_range(0, 65535)) :
             (kind == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535)) | 16'h8000;
      case (ph)
        0: begin word = '0; tk = 127; nb = 1; end
        1: begin tk = 3; nb = 2; end
        2: begin tk = 1; nb = 31; end
        default: begin
          tk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 3);
          nb = $urandom_range(0, 5);
        end
      endcase
      if (ph < 3 || $urandom_range(0, 2) != 0) write_reg(CFG_SYNC_PATTERN, word);
      if (ph < 3 || $urandom_range(0, 2) != 0) write_reg(CFG_TICKS_PER_BIT, 16'(tk));
      if (ph < 3 || $urandom_range(0, 2) != 0) write_reg(CFG_BYTES_PER_FRAME, 16'(nb));
      if ($urandom_range(0, 15) == 0)
        write_reg(CFG_IDX_UNUSED, 16'($urandom_range(0, 65535)));

      // idling for this phase; the long frame runs against a full hold-off
      if (ph == 2) begin
        tx_bursty <= 1'b0;
        sink_mode <= SINK_FREE;
        hold_req <= ~hold_req;
      end else if ($urandom_range(0, 3) == 0) begin
        tx_bursty <= 1'b0;
        sink_mode <= SINK_FREE;
      end else begin
        tx_bursty <= 1'($urandom_range(0, 1));
        sink_mode <= sink_mode_t'($urandom_range(0, 3));
      end

      kind = (ph < 3) ? 0 : $urandom_range(0, 9);
      if (ph == 0) begin
        // long bit period: start tick, one-bit sync and two data bits, frame ends next phase
        pin_q.push_back(1'b1);
        push_period(pin_q, 1'b0);
        repeat (2) push_period(pin_q, 1'($urandom_range(0, 1)));
        items_sent += 1 + 3 * period_ticks();
      end else if (kind < 7) begin
        queue_frame(FILL_RANDOM, 1'b0, 1'b0);
        if (ph >= 3 && $urandom_range(0, 1) == 1) queue_frame(FILL_RANDOM, 1'b0, 1'b1);
      end else if (kind == 7) begin
        queue_frame(FILL_RANDOM, 1'b1, 1'b0);
      end else begin
        // noise: random levels in any mode
        nb = $urandom_range(4, 40);
        repeat (nb) pin_q.push_back(1'($urandom_range(0, 1)));
        items_sent += nb;
      end
    end

    // drain
    waited = 0;
    while ((pin_q.size() != 0 || in_valid || byte_q.size() != 0) && waited < END_WAIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pin_q.size() != 0 || in_valid) report_err("ticks never accepted");
    if (byte_q.size() != 0) report_err($sformatf("%0d bytes never delivered", byte_q.size()));
    if (errors == 0) begin
      $display("sync_word_bit_deframer: match");
    end else begin
      $display("sync_word_bit_deframer: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("sync_word_bit_deframer: mismatch");
    $finish;
  end

endmodule
